// ===== src/sfr_pkg.sv =====
// Shared constants, types and register codes for the stream find-and-replace unit.
package sfr_pkg;

   localparam int PAT_MAX   = 8;
   localparam int REP_MAX   = 8;
   localparam int BURST_MAX = PAT_MAX + 1;
   localparam int FILL_W    = 4;
   localparam int CNT_W     = 4;
   localparam int LEN_W     = 4;
   localparam int WORD_W    = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LEN   = 2'd3;

   typedef logic [7:0] byte_type;

   // lengths already clamped to PAT_MAX / REP_MAX
   typedef struct packed {
      logic [WORD_W-1:0] pattern;
      logic [LEN_W-1:0]  plen;
      logic [WORD_W-1:0] replacement;
      logic [LEN_W-1:0]  rlen;
   } cfg_type;

   // burst of result bytes produced by one item
   typedef struct packed {
      logic [CNT_W-1:0]            count;
      byte_type [BURST_MAX-1:0]    bytes;
   } load_type;

endpackage

// ===== src/sfr_channels.sv =====
// Channel interfaces: text input, result output and register write port.
interface sfr_req_if import sfr_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type in_byte;
   logic     stream_last;
   modport source (output valid, output in_byte, output stream_last, input ready);
   modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

interface sfr_rsp_if import sfr_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     run_last;
   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

interface sfr_csr_if import sfr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [WORD_W-1:0]    data;
   modport source (output valid, output reg_index, output data, input ready);
   modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ===== src/sfr_csr.sv =====
// Configuration registers with length clamping.
module sfr_csr import sfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [WORD_W-1:0]    wr_data,
   output cfg_type              cfg
);

   logic [WORD_W-1:0] pattern_ff, pattern_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [WORD_W-1:0] replacement_ff, replacement_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;

   always_comb begin
      pattern_in     = pattern_ff;
      plen_in        = plen_ff;
      replacement_in = replacement_ff;
      rlen_in        = rlen_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_PATTERN_BYTES:     pattern_in     = wr_data;
            CSR_PATTERN_LEN:       plen_in        = wr_data[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES: replacement_in = wr_data;
            CSR_REPLACEMENT_LEN:   rlen_in        = wr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         plen_ff        <= '0;
         replacement_ff <= '0;
         rlen_ff        <= '0;
      end else begin
         pattern_ff     <= pattern_in;
         plen_ff        <= plen_in;
         replacement_ff <= replacement_in;
         rlen_ff        <= rlen_in;
      end
   end

   always_comb begin
      cfg.pattern     = pattern_ff;
      cfg.replacement = replacement_ff;
      cfg.plen = (plen_ff > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX) : plen_ff;
      cfg.rlen = (rlen_ff > LEN_W'(REP_MAX)) ? LEN_W'(REP_MAX) : rlen_ff;
   end

endmodule

// ===== src/sfr_window.sv =====
// Match window: holds candidate bytes, compares and builds each item's result burst.
module sfr_window import sfr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  byte_type in_byte,
   input  logic     stream_last,
   input  cfg_type  cfg,
   output load_type load
);

   byte_type [PAT_MAX-1:0] win_ff, win_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;

   byte_type [PAT_MAX-1:0] w_ins;
   logic [FILL_W-1:0]      fill_inc;
   logic                   pass, full, same;

   always_comb begin
      // insert the new byte at the fill position (fill < plen <= PAT_MAX here)
      for (int k = 0; k < PAT_MAX; k++) begin
         w_ins[k] = (FILL_W'(k) == fill_ff) ? in_byte : win_ff[k];
      end
      fill_inc = fill_ff + FILL_W'(1);
      pass = (in_byte == NEWLINE_BYTE) || (cfg.plen == '0) || (fill_ff >= cfg.plen);
      full = (fill_inc == cfg.plen);
      same = 1'b1;
      for (int k = 0; k < PAT_MAX; k++) begin
         if ((LEN_W'(k) < cfg.plen) && (w_ins[k] != cfg.pattern[8*k +: 8])) begin
            same = 1'b0;
         end
      end

      win_in       = win_ff;
      fill_in      = fill_ff;
      load.count   = '0;
      load.bytes   = '0;

      if (pass) begin
         // flush unmatched window, then the byte itself
         for (int k = 0; k < BURST_MAX; k++) begin
            if (k < PAT_MAX && FILL_W'(k) < fill_ff) begin
               load.bytes[k] = win_ff[k];
            end else begin
               load.bytes[k] = in_byte;
            end
         end
         load.count = CNT_W'(fill_ff) + CNT_W'(1);
         fill_in    = '0;
      end else if (full && same) begin
         for (int k = 0; k < REP_MAX; k++) begin
            load.bytes[k] = cfg.replacement[8*k +: 8];
         end
         load.count = CNT_W'(cfg.rlen);
         fill_in    = '0;
      end else if (stream_last) begin
         // full miss emits oldest then the rest; either way the whole window goes
         for (int k = 0; k < PAT_MAX; k++) begin
            load.bytes[k] = w_ins[k];
         end
         load.count = CNT_W'(fill_inc);
         fill_in    = '0;
      end else if (full) begin
         load.bytes[0] = w_ins[0];
         load.count    = CNT_W'(1);
         for (int k = 0; k < PAT_MAX; k++) begin
            win_in[k] = (k < PAT_MAX - 1) ? w_ins[(k + 1) % PAT_MAX] : w_ins[k];
         end
         fill_in = fill_ff;
      end else begin
         win_in  = w_ins;
         fill_in = fill_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (take) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== src/sfr_burst.sv =====
// Result buffer: holds one item's burst and shifts it out a byte at a time.
module sfr_burst import sfr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  load_type load,
   output logic     load_ok,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output byte_type out_byte,
   output logic     run_last
);

   byte_type [BURST_MAX-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign out_byte  = buf_ff[0];
   assign run_last  = (cnt_ff == CNT_W'(1));
   assign load_ok   = (cnt_ff == '0) || (run_last && rsp_ready);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (take) begin
         buf_in = load.bytes;
         cnt_in = load.count;
      end else if (pop) begin
         for (int k = 0; k < BURST_MAX; k++) begin
            buf_in[k] = (k < BURST_MAX - 1) ? buf_ff[(k + 1) % BURST_MAX] : buf_ff[k];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

// ===== src/stream_find_replace_unit.sv =====
// Top level of the streaming find-and-replace unit.
//
//  channel   dir  payload                         handshake
//  req_chan  in   in_byte[7:0], stream_last       valid / ready
//  rsp_chan  out  out_byte[7:0], run_last         valid / ready
//  csr_chan  in   reg_index[1:0], data[63:0]      valid / ready (ready tied high)
//
//  Each item is taken in a single handshake; its results (0 to 8 bytes) leave one per
//  cycle while rsp_chan.ready is high. Input is accepted when the result buffer is
//  empty or sends its final byte in that cycle, so items of at most one result flow at
//  one item per cycle while rsp_chan is ready; a longer item holds the input off until its final byte leaves.
//  Reset is synchronous, active high; it clears the configuration, the window fill and the result count.
//  Stalls on rsp_chan back up straight into req_chan.ready.
module stream_find_replace_unit import sfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sfr_req_if.sink    req_chan,
   sfr_rsp_if.source  rsp_chan,
   sfr_csr_if.sink    csr_chan
);

   cfg_type  cfg;
   load_type load;
   logic     load_ok;
   logic     take;

   // register port never stalls
   assign csr_chan.ready = 1'b1;

   assign req_chan.ready = load_ok;
   assign take           = req_chan.valid && load_ok;

   sfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_index (csr_chan.reg_index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   // window update and burst build, all within the accept cycle
   sfr_window u_window (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_chan.in_byte),
      .stream_last (req_chan.stream_last),
      .cfg         (cfg),
      .load        (load)
   );

   // result register: doubles as the skid between the two sides
   sfr_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .load      (load),
      .load_ok   (load_ok),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .run_last  (rsp_chan.run_last)
   );

   // a new item only lands once the previous burst is done or finishing
   a_take_after_burst: assert property (@(posedge clock) disable iff (reset)
      take |-> (!rsp_chan.valid || (rsp_chan.ready && rsp_chan.run_last)))
      else $error("item taken while a burst is still pending");

   // an item with results shows them next cycle; one without leaves output idle
   a_burst_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_chan.valid == ($past(load.count) != '0)))
      else $error("result presence does not match burst length");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      take |-> (load.count <= CNT_W'(BURST_MAX)))
      else $error("burst longer than the result buffer");

endmodule
